@@ rtl/tfu_pkg.sv @@
// Shared widths, constants, codes and pipeline structs of the Taylor series trig unit.
// Depends on nothing; every other file refers to it by scoped names.
package tfu_pkg;

   localparam int FRAC_BITS = 24;
   localparam int MAX_TERMS = 12;

   localparam int ANGLE_W = 32;
   localparam int MAG_W   = 32;
   localparam int TOL_W   = 24;
   localparam int OUT_W   = 48;
   localparam int STAT_W  = 3;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(17);

   // Pi with 62 fraction bits, rounded to nearest at FRAC_BITS.
   localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C235;
   localparam logic [63:0] K_PI      = (PI_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
   localparam logic [63:0] K_HALF_PI = (PI_Q62 + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS);
   localparam logic [63:0] K_TWO_PI  = (PI_Q62 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);

   // Angle after the modulo (below 2*pi) and after folding (at most pi/2).
   localparam int R_W  = FRAC_BITS + 3;
   localparam int A_W  = FRAC_BITS + 1;
   // Term magnitude, partial product after one multiply, dividend of the term divide.
   localparam int M_W  = FRAC_BITS + 1;
   localparam int T1_W = FRAC_BITS + 2;
   localparam int X_W  = FRAC_BITS + 4;
   localparam int RC_W = X_W + 2;
   localparam int Y_W  = X_W + RC_W;
   // Signed series sum.
   localparam int S_W  = FRAC_BITS + 3;

   // Quotient bits of the modulo 2*pi (2*pi is at least 2^(FRAC_BITS+2)).
   localparam int QB = (MAG_W - FRAC_BITS - 2 > 0) ? (MAG_W - FRAC_BITS - 2) : 1;
   // Dividend width of the tangent and cotangent quotient.
   localparam int NW = S_W + FRAC_BITS + 1;

   localparam logic [63:0] OUT_MAX = (64'd1 << (OUT_W - 1)) - 64'd1;

   typedef enum logic [1:0] {
      OP_SIN = 2'd0,
      OP_COS = 2'd1,
      OP_TAN = 2'd2,
      OP_COT = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_POS_INF   = 3'd1,
      ST_NEG_INF   = 3'd2,
      ST_ZERO_ZERO = 3'd3,
      ST_SATURATED = 3'd4
   } status_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   negin;
   } front_type;

   typedef struct packed {
      logic [A_W-1:0]        a;
      logic [M_W-1:0]        m;
      logic signed [S_W-1:0] s;
      logic                  done;
      logic                  neg;
   } lane_type;

   typedef struct packed {
      logic                  valid;
      logic                  is_div;
      logic                  zero_div;
      logic                  neg;
      status_type            zstat;
      logic signed [S_W-1:0] direct;
   } div_type;

endpackage

@@ rtl/tfu_series.sv @@
// Pipelined Maclaurin series for the sine and cosine lanes, four stages per term.
// Depends on tfu_pkg for widths, the lane struct and the control struct.
module tfu_series (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic [tfu_pkg::TOL_W-1:0]          tolerance,
   input  tfu_pkg::ctrl_type                  ctrl_in,
   input  tfu_pkg::lane_type                  sin_lane_in,
   input  tfu_pkg::lane_type                  cos_lane_in,
   output tfu_pkg::ctrl_type                  ctrl_out,
   output logic signed [tfu_pkg::S_W-1:0]     sin_val,
   output logic signed [tfu_pkg::S_W-1:0]     cos_val
);

   localparam int T = tfu_pkg::MAX_TERMS;
   localparam int F = tfu_pkg::FRAC_BITS;

   tfu_pkg::ctrl_type ctrl_b [0:T-1];
   tfu_pkg::lane_type lane_b [0:T-1][0:1];

   assign ctrl_b[0]    = ctrl_in;
   assign lane_b[0][0] = sin_lane_in;
   assign lane_b[0][1] = cos_lane_in;

   for (genvar k = 1; k < T; k++) begin : g_term
      tfu_pkg::ctrl_type c1_in, c1_ff, c2_in, c2_ff, c3_in, c3_ff, c4_in, c4_ff;

      assign c1_in = ctrl_b[k-1];
      assign c2_in = c1_ff;
      assign c3_in = c2_ff;
      assign c4_in = c3_ff;
      assign ctrl_b[k] = c4_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            c1_ff <= '0;
            c2_ff <= '0;
            c3_ff <= '0;
            c4_ff <= '0;
         end else if (adv) begin
            c1_ff <= c1_in;
            c2_ff <= c2_in;
            c3_ff <= c3_in;
            c4_ff <= c4_in;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         // Sine lane divides by n*(n-1) starting at n = 3, cosine at n = 2.
         localparam int N  = ((l == 0) ? 3 : 2) + 2 * (k - 1);
         localparam int D  = N * (N - 1);
         localparam int L  = $clog2(D);
         localparam int SH = tfu_pkg::X_W + L;
         localparam logic [63:0] RC = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);
         localparam logic [63:0] HALF_D = 64'(D) / 64'd2;

         tfu_pkg::lane_type s1_in, s1_ff, s2_ff, s3_ff, s4_in, s4_ff;
         logic [tfu_pkg::M_W+tfu_pkg::A_W:0]  p1;
         logic [tfu_pkg::T1_W+tfu_pkg::A_W:0] p2;
         logic [tfu_pkg::T1_W-1:0]           t1_in, t1_ff;
         logic [tfu_pkg::X_W-1:0]            x_in, x_ff;
         logic [tfu_pkg::Y_W-1:0]            y_in, y_ff;
         logic [tfu_pkg::M_W-1:0]            m_new;

         // The term is skipped once the previous term is at or below tolerance.
         always_comb begin
            s1_in      = lane_b[k-1][l];
            s1_in.done = lane_b[k-1][l].done ||
                         !(64'(lane_b[k-1][l].m) > 64'(tolerance));
         end

         assign p1    = (tfu_pkg::M_W+tfu_pkg::A_W+1)'(lane_b[k-1][l].m) *
                        (tfu_pkg::M_W+tfu_pkg::A_W+1)'(lane_b[k-1][l].a);
         assign t1_in = tfu_pkg::T1_W'((p1 + (tfu_pkg::M_W+tfu_pkg::A_W+1)'(1 << (F-1))) >> F);

         assign p2    = (tfu_pkg::T1_W+tfu_pkg::A_W+1)'(t1_ff) *
                        (tfu_pkg::T1_W+tfu_pkg::A_W+1)'(s1_ff.a);
         assign x_in  = tfu_pkg::X_W'((p2 + (tfu_pkg::T1_W+tfu_pkg::A_W+1)'(1 << (F-1))) >> F)
                        + tfu_pkg::X_W'(HALF_D);

         // Exact floor division by D through a rounded-up reciprocal.
         assign y_in  = tfu_pkg::Y_W'(x_ff) * tfu_pkg::Y_W'(RC[tfu_pkg::RC_W-1:0]);

         assign m_new = tfu_pkg::M_W'(y_ff >> SH);

         always_comb begin
            s4_in = s3_ff;
            if (!s3_ff.done) begin
               s4_in.m = m_new;
               if ((k % 2) == 1) begin
                  s4_in.s = s3_ff.s - tfu_pkg::S_W'(m_new);
               end else begin
                  s4_in.s = s3_ff.s + tfu_pkg::S_W'(m_new);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               s1_ff <= s1_in;
               t1_ff <= t1_in;
               s2_ff <= s1_ff;
               x_ff  <= x_in;
               s3_ff <= s2_ff;
               y_ff  <= y_in;
               s4_ff <= s4_in;
            end
         end

         assign lane_b[k][l] = s4_ff;
      end
   end

   assign ctrl_out = ctrl_b[T-1];
   assign sin_val  = lane_b[T-1][0].neg ? -lane_b[T-1][0].s : lane_b[T-1][0].s;
   assign cos_val  = lane_b[T-1][1].neg ? -lane_b[T-1][1].s : lane_b[T-1][1].s;

endmodule

@@ rtl/tfu_divide.sv @@
// Pipelined restoring divider for tangent and cotangent, one quotient bit per stage,
// with near-zero divisor and saturation handling. Depends on tfu_pkg.
module tfu_divide (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic [tfu_pkg::TOL_W-1:0]          tolerance,
   input  tfu_pkg::ctrl_type                  ctrl_in,
   input  logic signed [tfu_pkg::S_W-1:0]     sin_val,
   input  logic signed [tfu_pkg::S_W-1:0]     cos_val,
   output logic                               out_valid,
   output logic signed [tfu_pkg::OUT_W-1:0]   out_value,
   output tfu_pkg::status_type                out_status
);

   localparam int NW  = tfu_pkg::NW;
   localparam int S_W = tfu_pkg::S_W;
   localparam int F   = tfu_pkg::FRAC_BITS;

   tfu_pkg::div_type        e_in, e_ff;
   logic signed [S_W-1:0]   num, den;
   logic [S_W-1:0]          un, ud_in, ud_ff;
   logic [NW-1:0]           x_in, x_ff;

   always_comb begin
      if (ctrl_in.op == tfu_pkg::OP_COT) begin
         num = cos_val;
         den = sin_val;
      end else begin
         num = sin_val;
         den = cos_val;
      end
      un    = num[S_W-1] ? S_W'(-num) : S_W'(num);
      ud_in = den[S_W-1] ? S_W'(-den) : S_W'(den);
      x_in  = (NW'(un) << F) + NW'(ud_in >> 1);

      e_in          = '0;
      e_in.valid    = ctrl_in.valid;
      e_in.is_div   = (ctrl_in.op == tfu_pkg::OP_TAN) || (ctrl_in.op == tfu_pkg::OP_COT);
      e_in.zero_div = (ud_in == '0) || (64'(ud_in) < 64'(tolerance));
      e_in.neg      = num[S_W-1] != den[S_W-1];
      e_in.direct   = (ctrl_in.op == tfu_pkg::OP_SIN) ? sin_val : cos_val;
      if (num > 0) begin
         e_in.zstat = tfu_pkg::ST_POS_INF;
      end else if (num < 0) begin
         e_in.zstat = tfu_pkg::ST_NEG_INF;
      end else begin
         e_in.zstat = tfu_pkg::ST_ZERO_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff <= '0;
      end else if (adv) begin
         e_ff <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ud_ff <= ud_in;
         x_ff  <= x_in;
      end
   end

   tfu_pkg::div_type  d_b   [0:NW];
   logic [S_W-1:0]    ud_b  [0:NW];
   logic [S_W-1:0]    rem_b [0:NW];
   logic [NW-1:0]     x_b   [0:NW];
   logic [NW-1:0]     q_b   [0:NW];

   assign d_b[0]   = e_ff;
   assign ud_b[0]  = ud_ff;
   assign rem_b[0] = '0;
   assign x_b[0]   = x_ff;
   assign q_b[0]   = '0;

   for (genvar i = 0; i < NW; i++) begin : g_bit
      tfu_pkg::div_type d_ff;
      logic [S_W-1:0]   ud_q, rem_in, rem_ff;
      logic [NW-1:0]    x_q, q_in, q_ff;
      logic [S_W:0]     trial;

      // Bring down the next dividend bit, most significant first.
      assign trial = {rem_b[i], x_b[i][NW-1-i]};

      always_comb begin
         if (trial >= (S_W+1)'(ud_b[i])) begin
            rem_in = S_W'(trial - (S_W+1)'(ud_b[i]));
            q_in   = {q_b[i][NW-2:0], 1'b1};
         end else begin
            rem_in = S_W'(trial);
            q_in   = {q_b[i][NW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_ff <= '0;
         end else if (adv) begin
            d_ff <= d_b[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ud_q   <= ud_b[i];
            x_q    <= x_b[i];
            rem_ff <= rem_in;
            q_ff   <= q_in;
         end
      end

      assign d_b[i+1]   = d_ff;
      assign ud_b[i+1]  = ud_q;
      assign x_b[i+1]   = x_q;
      assign rem_b[i+1] = rem_ff;
      assign q_b[i+1]   = q_ff;
   end

   tfu_pkg::div_type         fin;
   logic [NW-1:0]            q_fin;
   logic [tfu_pkg::OUT_W-1:0] q_out;

   assign fin   = d_b[NW];
   assign q_fin = q_b[NW];
   assign q_out = tfu_pkg::OUT_W'(q_fin);

   always_comb begin
      out_valid = fin.valid;
      if (!fin.is_div) begin
         out_value  = tfu_pkg::OUT_W'(fin.direct);
         out_status = tfu_pkg::ST_OK;
      end else if (fin.zero_div) begin
         out_value  = '0;
         out_status = fin.zstat;
      end else if (64'(q_fin) > tfu_pkg::OUT_MAX) begin
         out_value  = fin.neg ? ~tfu_pkg::OUT_W'(tfu_pkg::OUT_MAX)
                              : tfu_pkg::OUT_W'(tfu_pkg::OUT_MAX);
         out_status = tfu_pkg::ST_SATURATED;
      end else begin
         out_value  = fin.neg ? -q_out : q_out;
         out_status = tfu_pkg::ST_OK;
      end
   end

endmodule

@@ rtl/taylor_trig_function_unit.sv @@
// Sine, cosine, tangent and cotangent of a Q8.24 angle by Maclaurin series.
// A request beat passes the input register, six modulo steps, the fold register, eleven
// four-stage series terms, quotient setup, 52 quotient bits and the output register.
// Throughput is one beat per cycle; a stalled response freezes the whole pipeline.
// Synchronous active-high reset clears all valid bits and loads tolerance with 17.
// Depends on tfu_pkg, tfu_series and tfu_divide.
module taylor_trig_function_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic signed [tfu_pkg::ANGLE_W-1:0]  req_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tfu_pkg::OUT_W-1:0]    rsp_result_value,
   output logic [tfu_pkg::STAT_W-1:0]          rsp_status,
   input  logic                                csr_wr_en,
   input  logic [tfu_pkg::TOL_W-1:0]           csr_wr_data
);

   localparam int QB    = tfu_pkg::QB;
   localparam int MAG_W = tfu_pkg::MAG_W;
   localparam int R_W   = tfu_pkg::R_W;
   localparam int A_W   = tfu_pkg::A_W;
   localparam int F     = tfu_pkg::FRAC_BITS;

   // Every stage moves only when the output register can take a new beat.
   logic adv;
   logic rsp_valid_ff, rsp_valid_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // The user must write the tolerance register only while the pipeline is empty; the block does not enforce it.
   logic [tfu_pkg::TOL_W-1:0] tolerance_ff, tolerance_in;

   assign tolerance_in = csr_wr_en ? csr_wr_data : tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= tfu_pkg::TOL_RESET;
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   // Input register: take the magnitude of the angle and remember its sign.
   tfu_pkg::front_type front_in, front_ff;
   logic [MAG_W-1:0]   mag_in, mag_ff;

   always_comb begin
      front_in.valid = req_valid;
      front_in.op    = tfu_pkg::op_type'(req_op);
      front_in.negin = req_angle[tfu_pkg::ANGLE_W-1];
      mag_in         = front_in.negin ? MAG_W'(-req_angle) : MAG_W'(req_angle);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
      end else if (adv) begin
         front_ff <= front_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
      end
   end

   // Modulo 2*pi as a restoring division, one quotient bit per stage.
   tfu_pkg::front_type md_b   [0:QB];
   logic [MAG_W-1:0]   md_r_b [0:QB];

   assign md_b[0]   = front_ff;
   assign md_r_b[0] = mag_ff;

   for (genvar j = 0; j < QB; j++) begin : g_mod
      localparam logic [63:0] SUB = tfu_pkg::K_TWO_PI << (QB - 1 - j);

      tfu_pkg::front_type md_ff;
      logic [MAG_W-1:0]   r_in, r_ff;

      assign r_in = (64'(md_r_b[j]) >= SUB) ? md_r_b[j] - MAG_W'(SUB) : md_r_b[j];

      always_ff @(posedge clock) begin
         if (reset) begin
            md_ff <= '0;
         end else if (adv) begin
            md_ff <= md_b[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff <= r_in;
         end
      end

      assign md_b[j+1]   = md_ff;
      assign md_r_b[j+1] = r_ff;
   end

   // Fold the reduced angle into [0, pi/2] for each lane and tracks the sign of the
   // result: sine flips above pi, cosine flips between pi/2 and 3*pi/2.
   localparam logic [R_W-1:0] KPI  = R_W'(tfu_pkg::K_PI);
   localparam logic [R_W-1:0] KHPI = R_W'(tfu_pkg::K_HALF_PI);
   localparam logic [R_W-1:0] K2PI = R_W'(tfu_pkg::K_TWO_PI);

   logic [R_W-1:0]    r_fold, sa, ca;
   logic              sneg, cneg;
   tfu_pkg::ctrl_type fold_ctrl_in, fold_ctrl_ff;
   tfu_pkg::lane_type sin_lane_in, sin_lane_ff, cos_lane_in, cos_lane_ff;

   always_comb begin
      r_fold = R_W'(md_r_b[QB]);

      sa   = r_fold;
      sneg = md_b[QB].negin;
      if (r_fold > KPI) begin
         sa   = r_fold - KPI;
         sneg = !md_b[QB].negin;
      end
      if (sa > KHPI) begin
         sa = KPI - sa;
      end

      ca   = r_fold;
      cneg = 1'b0;
      if (r_fold > KPI) begin
         ca = K2PI - r_fold;
      end
      if (ca > KHPI) begin
         ca   = KPI - ca;
         cneg = 1'b1;
      end

      fold_ctrl_in.valid = md_b[QB].valid;
      fold_ctrl_in.op    = md_b[QB].op;

      // Sine starts from the angle itself, cosine from one.
      sin_lane_in.a    = A_W'(sa);
      sin_lane_in.m    = tfu_pkg::M_W'(sa);
      sin_lane_in.s    = tfu_pkg::S_W'(sa);
      sin_lane_in.done = 1'b0;
      sin_lane_in.neg  = sneg;

      cos_lane_in.a    = A_W'(ca);
      cos_lane_in.m    = tfu_pkg::M_W'(1) << F;
      cos_lane_in.s    = tfu_pkg::S_W'(1) << F;
      cos_lane_in.done = 1'b0;
      cos_lane_in.neg  = cneg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ctrl_ff <= '0;
      end else if (adv) begin
         fold_ctrl_ff <= fold_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_lane_ff <= sin_lane_in;
         cos_lane_ff <= cos_lane_in;
      end
   end

   // Series for both lanes in parallel; tangent and cotangent need both.
   tfu_pkg::ctrl_type            ser_ctrl;
   logic signed [tfu_pkg::S_W-1:0] sin_val, cos_val;

   tfu_series u_series (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .tolerance   (tolerance_ff),
      .ctrl_in     (fold_ctrl_ff),
      .sin_lane_in (sin_lane_ff),
      .cos_lane_in (cos_lane_ff),
      .ctrl_out    (ser_ctrl),
      .sin_val     (sin_val),
      .cos_val     (cos_val)
   );

   // Quotient for tangent and cotangent; sine and cosine ride along unchanged.
   logic                             div_valid;
   logic signed [tfu_pkg::OUT_W-1:0] div_value;
   tfu_pkg::status_type              div_status;

   tfu_divide u_divide (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .tolerance  (tolerance_ff),
      .ctrl_in    (ser_ctrl),
      .sin_val    (sin_val),
      .cos_val    (cos_val),
      .out_valid  (div_valid),
      .out_value  (div_value),
      .out_status (div_status)
   );

   // Output register holds a beat until the consumer drops stall.
   logic signed [tfu_pkg::OUT_W-1:0] rsp_value_ff, rsp_value_in;
   tfu_pkg::status_type              rsp_status_ff, rsp_status_in;

   assign rsp_valid_in  = div_valid;
   assign rsp_value_in  = div_value;
   assign rsp_status_in = div_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

@@ dv/taylor_trig_function_unit_test.sv @@
// Self-checking testbench of the Taylor series trig unit: directed and random beats
// under random idling, checked against a bit-exact fixed-point predictor of each function.
// Depends on tfu_pkg and the taylor_trig_function_unit RTL.
module taylor_trig_function_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected response beat.
   typedef struct {
      logic [tfu_pkg::OUT_W-1:0] value;
      tfu_pkg::status_type       status;
   } trig_answer_type;

   // Predicts each response from the tolerance and the request, and checks the
   // responses in order against those predictions.
   class trig_scoreboard;
      logic [tfu_pkg::TOL_W-1:0] tolerance;
      trig_answer_type           pending[$];
      int                        errors;

      function new();
         tolerance = tfu_pkg::TOL_RESET;
         errors    = 0;
      endfunction

      // Fixed-point multiply with the product rounded half up.
      function longint unsigned mul_round(longint unsigned u, longint unsigned v);
         return (u * v + (64'd1 << (tfu_pkg::FRAC_BITS - 1))) >> tfu_pkg::FRAC_BITS;
      endfunction

      // Sums the series on a folded angle from a first term and divisor index.
      function longint sum_series(longint unsigned a, longint unsigned m0, int unsigned n0);
         longint unsigned m, d, p;
         longint          s;
         bit              neg;
         int unsigned     n;
         int              terms;
         m = m0;
         s = longint'(m0);
         neg = 0;
         n = n0;
         terms = 1;
         while (m > longint'(tolerance) && terms < tfu_pkg::MAX_TERMS) begin
            d = longint'(n) * longint'(n - 1);
            p = mul_round(mul_round(m, a), a);
            m = (p + d / 2) / d;
            neg = !neg;
            if (neg) s -= longint'(m);
            else s += longint'(m);
            n += 2;
            terms++;
         end
         return s;
      endfunction

      function longint sine_of(bit negin, longint unsigned mag);
         longint unsigned a;
         bit              neg;
         longint          s;
         a = mag % tfu_pkg::K_TWO_PI;
         neg = negin;
         if (a > tfu_pkg::K_PI) begin
            a -= tfu_pkg::K_PI;
            neg = !neg;
         end
         if (a > tfu_pkg::K_HALF_PI) a = tfu_pkg::K_PI - a;
         s = sum_series(a, a, 3);
         return neg ? -s : s;
      endfunction

      function longint cosine_of(longint unsigned mag);
         longint unsigned a;
         bit              neg;
         longint          s;
         a = mag % tfu_pkg::K_TWO_PI;
         neg = 0;
         if (a > tfu_pkg::K_PI) a = tfu_pkg::K_TWO_PI - a;
         if (a > tfu_pkg::K_HALF_PI) begin
            a = tfu_pkg::K_PI - a;
            neg = 1;
         end
         s = sum_series(a, 64'd1 << tfu_pkg::FRAC_BITS, 2);
         return neg ? -s : s;
      endfunction

      // Tangent and cotangent quotient, with the near-zero divisor and
      // saturation cases folded into the status.
      function trig_answer_type quotient(longint num, longint den);
         trig_answer_type r;
         longint unsigned un, ud, q;
         bit              neg;
         un = (num < 0) ? -num : num;
         ud = (den < 0) ? -den : den;
         r.value = '0;
         r.status = tfu_pkg::ST_OK;
         if (ud == 0 || ud < longint'(tolerance)) begin
            if (num > 0) r.status = tfu_pkg::ST_POS_INF;
            else if (num < 0) r.status = tfu_pkg::ST_NEG_INF;
            else r.status = tfu_pkg::ST_ZERO_ZERO;
            return r;
         end
         q = ((un << tfu_pkg::FRAC_BITS) + ud / 2) / ud;
         neg = (num < 0) != (den < 0);
         if (q > tfu_pkg::OUT_MAX) begin
            r.status = tfu_pkg::ST_SATURATED;
            r.value = neg ? {1'b1, {(tfu_pkg::OUT_W-1){1'b0}}}
                          : {1'b0, {(tfu_pkg::OUT_W-1){1'b1}}};
            return r;
         end
         r.value = neg ? tfu_pkg::OUT_W'(-longint'(q)) : tfu_pkg::OUT_W'(q);
         return r;
      endfunction

      function void note_request(tfu_pkg::op_type op, logic [tfu_pkg::ANGLE_W-1:0] angle);
         trig_answer_type r;
         bit              negin;
         longint unsigned mag;
         longint          sv, cv;
         negin = angle[tfu_pkg::ANGLE_W-1];
         mag = negin ? (64'h1_0000_0000 - longint'(angle)) : longint'(angle);
         r.status = tfu_pkg::ST_OK;
         case (op)
            tfu_pkg::OP_SIN: r.value = tfu_pkg::OUT_W'(sine_of(negin, mag));
            tfu_pkg::OP_COS: r.value = tfu_pkg::OUT_W'(cosine_of(mag));
            default: begin
               sv = sine_of(negin, mag);
               cv = cosine_of(mag);
               r = (op == tfu_pkg::OP_TAN) ? quotient(sv, cv) : quotient(cv, sv);
            end
         endcase
         pending.push_back(r);
      endfunction

      function void report(string what, longint exp_v, longint act_v);
         errors++;
         if (errors <= 10)
            $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, exp_v, act_v);
      endfunction

      function void check_response(logic [tfu_pkg::OUT_W-1:0] value,
                                   logic [tfu_pkg::STAT_W-1:0] status);
         trig_answer_type e;
         if (pending.size() == 0) begin
            report("unexpected beat (value)", 0, $signed(value));
            return;
         end
         e = pending.pop_front();
         if (value !== e.value) report("result_value", $signed(e.value), $signed(value));
         if (status !== e.status) report("status", e.status, status);
      endfunction
   endclass

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_valid = 0;
   logic                                req_stall;
   logic [1:0]                          req_op = '0;
   logic signed [tfu_pkg::ANGLE_W-1:0]  req_angle = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 0;
   logic signed [tfu_pkg::OUT_W-1:0]    rsp_result_value;
   logic [tfu_pkg::STAT_W-1:0]          rsp_status;
   logic                                csr_wr_en = 0;
   logic [tfu_pkg::TOL_W-1:0]           csr_wr_data = '0;

   trig_scoreboard board = new();
   bit             sender_done = 0;
   int             send_quiet = 0;
   int             recv_quiet = 0;

   always #5 clock = ~clock;

   taylor_trig_function_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_angle        (req_angle),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // Draws a random idle count, which may be zero. Now and then a side enters a
   // stretch of beats with no idling at all, so back-to-back traffic is seen too.
   function automatic int idle_cycles(ref int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         quiet = $urandom_range(5, 30);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // Offers one request beat and returns once it has been taken. Valid is
   // only lowered when a gap is drawn, so back-to-back beats keep it high.
   task automatic send_beat(tfu_pkg::op_type op, logic [tfu_pkg::ANGLE_W-1:0] angle);
      int gap;
      gap = idle_cycles(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_angle <= angle;
      // Signals read right after the edge still hold their pre-edge values,
      // which are the ones that decided whether the beat was taken.
      do @(posedge clock); while (req_stall);
      board.note_request(op, angle);
   endtask

   // Waits for the pipeline to drain, then writes the tolerance register.
   task automatic write_tolerance(logic [tfu_pkg::TOL_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.tolerance = value;
   endtask

   // Angle picker for the random part: the full range, small angles, and
   // angles just around multiples of pi/2 where the quotients blow up.
   function automatic logic [tfu_pkg::ANGLE_W-1:0] random_angle();
      longint base;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return tfu_pkg::ANGLE_W'($signed($urandom_range(0, 32'h0400_0000))
                                     - 32'sh0200_0000);
         default: begin
            base = longint'($urandom_range(0, 80)) * tfu_pkg::K_HALF_PI;
            base = base + $signed($urandom_range(0, 64)) - 32;
            if ($urandom_range(0, 1)) base = -base;
            return tfu_pkg::ANGLE_W'(base);
         end
      endcase
   endfunction

   // Directed beats: every function at the extremes of the angle, at zero,
   // and at the points where sine or cosine vanishes.
   task automatic directed_beats();
      logic [tfu_pkg::ANGLE_W-1:0] pts[6];
      pts[0] = '0;
      pts[1] = 32'h7FFF_FFFF;
      pts[2] = 32'h8000_0000;
      pts[3] = tfu_pkg::ANGLE_W'(tfu_pkg::K_HALF_PI);
      pts[4] = tfu_pkg::ANGLE_W'(-longint'(tfu_pkg::K_PI));
      pts[5] = tfu_pkg::ANGLE_W'(3 * tfu_pkg::K_HALF_PI + 1);
      foreach (pts[i])
         for (int k = 0; k < 4; k++) send_beat(tfu_pkg::op_type'(k), pts[i]);
   endtask

   // Response side: stall for a random count, then accept one beat.
   initial begin : response_idler
      int n;
      @(negedge reset);
      forever begin
         n = idle_cycles(recv_quiet);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Every response beat taken at an edge is checked in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_result_value, rsp_status);
   end

   initial begin : stimulus
      logic [tfu_pkg::TOL_W-1:0] settings[5];
      settings[0] = tfu_pkg::TOL_RESET;
      settings[1] = 24'd1;
      settings[2] = 24'hFF_FFFF;
      settings[3] = 24'd4096;
      settings[4] = tfu_pkg::TOL_W'($urandom_range(2, 2000));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < 5; ph++) begin
         write_tolerance(settings[ph]);
         directed_beats();
         for (int i = 0; i < 126; i++) begin
            // Once per run the sender holds off until everything has drained.
            if (ph == 2 && i == 75) begin
               req_valid <= 1'b0;
               while (board.pending.size() != 0) @(posedge clock);
            end
            send_beat(tfu_pkg::op_type'($urandom_range(0, 3)), random_angle());
         end
      end
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      // Let any stray beat show up before the verdict.
      repeat (150) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      #8ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tfu_pkg.sv
rtl/tfu_series.sv
rtl/tfu_divide.sv
rtl/taylor_trig_function_unit.sv
dv/taylor_trig_function_unit_test.sv
